[src/assert_macros.svh]
// assertion macros used by the checker file vva_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define VVA_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define VVA_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[src/vva_pkg.sv]
// types, constants and helpers of the velocity verlet atom update
package vva_pkg;

  localparam int unsigned DivSteps = 32;
  localparam int unsigned NumAxes  = 3;

  // register indexes of the configuration port
  localparam logic [2:0] RegForceStep = 3'd0;
  localparam logic [2:0] RegTimeStep  = 3'd1;
  localparam logic [2:0] RegGroup     = 3'd2;
  localparam logic [2:0] RegPhase     = 3'd3;

  // atom data travelling alongside the divider
  typedef struct packed {
    logic [NumAxes-1:0][31:0] pos;
    logic [NumAxes-1:0][31:0] vel;
    logic [NumAxes-1:0][31:0] frc;
    logic                     grp;
    logic                     sat;
    logic                     last;
  } item_t;

  // clamp a wide sum to signed 32 bits; top bit flags a clamp
  function automatic logic [32:0] clamp50(input logic signed [49:0] v);
    logic [32:0] r;
    if (v > 50'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -50'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

[src/vva_divider.sv]
// pipelined restoring divider, one quotient bit per stage
module vva_divider import vva_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  item_t       item_i,
  input  logic [31:0] rem_i,
  input  logic [31:0] den_i,
  input  logic [31:0] num_i,
  output logic        valid_o,
  output item_t       item_o,
  output logic [31:0] quo_o
);

  logic        valid_q [DivSteps];
  item_t       item_q  [DivSteps];
  logic [31:0] rem_q   [DivSteps];
  logic [31:0] den_q   [DivSteps];
  logic [31:0] num_q   [DivSteps];
  logic [31:0] quo_q   [DivSteps];

  logic [31:0] rem_src [DivSteps];
  logic [31:0] den_src [DivSteps];
  logic [31:0] num_src [DivSteps];
  logic [31:0] quo_src [DivSteps];
  logic [31:0] rem_d   [DivSteps];
  logic        qbit_d  [DivSteps];

  // one compare and subtract per stage
  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      logic [32:0] shifted;
      logic [32:0] diff;
      if (k == 0) begin
        rem_src[k] = rem_i;
        den_src[k] = den_i;
        num_src[k] = num_i;
        quo_src[k] = '0;
      end else begin
        rem_src[k] = rem_q[k-1];
        den_src[k] = den_q[k-1];
        num_src[k] = num_q[k-1];
        quo_src[k] = quo_q[k-1];
      end
      shifted = {rem_src[k], num_src[k][31]};
      diff    = shifted - {1'b0, den_src[k]};
      qbit_d[k] = ~diff[32];
      rem_d[k]  = diff[32] ? shifted[31:0] : diff[31:0];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivSteps; k++) valid_q[k] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 1; k < DivSteps; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q[0] <= item_i;
      for (int k = 1; k < DivSteps; k++) begin
        item_q[k] <= item_q[k-1];
      end
      for (int k = 0; k < DivSteps; k++) begin
        rem_q[k]  <= rem_d[k];
        den_q[k]  <= den_src[k];
        num_q[k]  <= {num_src[k][30:0], 1'b0};
        quo_q[k]  <= {quo_src[k][30:0], qbit_d[k]};
      end
    end
  end

  assign valid_o = valid_q[DivSteps-1];
  assign item_o  = item_q[DivSteps-1];
  assign quo_o   = quo_q[DivSteps-1];

endmodule

[src/vva_lane.sv]
// one axis: velocity kick then position drift, four register stages
module vva_lane import vva_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] factor_i,
  input  logic [31:0] time_step_i,
  input  logic        phase_i,
  input  logic        grp_i,
  input  logic [31:0] pos_i,
  input  logic [31:0] vel_i,
  input  logic [31:0] frc_i,
  output logic [31:0] pos_o,
  output logic [31:0] vel_o,
  output logic        sat_o
);

  logic signed [64:0] prod1_q, prod2_q;
  logic [31:0] pos1_q, vel1_q, pos2_q, vel2_q, pos3_q, vel3_q, pos4_q, vel4_q;
  logic        grp1_q, grp2_q, grp3_q, ph1_q, ph2_q, ph3_q, sv2_q, sv3_q, sat4_q;
  logic [32:0] vsum, psum;

  assign vsum = clamp50(50'(signed'(vel1_q)) + 50'(prod1_q >>> 16));
  assign psum = clamp50(50'(signed'(pos3_q)) + 50'(prod2_q >>> 16));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // factor times force
      prod1_q <= signed'({1'b0, factor_i}) * 65'(signed'(frc_i));
      pos1_q  <= pos_i;
      vel1_q  <= vel_i;
      grp1_q  <= grp_i;
      ph1_q   <= phase_i;
      // new velocity
      vel2_q  <= grp1_q ? vsum[31:0] : vel1_q;
      sv2_q   <= grp1_q & vsum[32];
      pos2_q  <= pos1_q;
      grp2_q  <= grp1_q;
      ph2_q   <= ph1_q;
      // time step times new velocity
      prod2_q <= signed'({1'b0, time_step_i}) * 65'(signed'(vel2_q));
      vel3_q  <= vel2_q;
      pos3_q  <= pos2_q;
      sv3_q   <= sv2_q;
      grp3_q  <= grp2_q;
      ph3_q   <= ph2_q;
      // new position
      pos4_q  <= (grp3_q && !ph3_q) ? psum[31:0] : pos3_q;
      vel4_q  <= vel3_q;
      sat4_q  <= sv3_q | (grp3_q & ~ph3_q & psum[32]);
    end
  end

  assign pos_o = pos4_q;
  assign vel_o = vel4_q;
  assign sat_o = sat4_q;

endmodule

[src/velocity_verlet_atom_update.sv]
// top level of the velocity verlet atom update
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | atom mask, mass, pos, vel, force, last
//   out     | output    | out_valid_o / out_stall_i| new pos, new vel, in_group, saturated, end
//   cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// one item per cycle while the output is not stalled; input register, 32 divider stages
// (one quotient bit each) and four multiply/add stages per axis
// reset clears the valid bits and loads the register reset values
// a stall on a valid output freezes the whole pipeline; nothing is dropped
module velocity_verlet_atom_update import vva_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] atom_mask_i,
  input  logic [31:0] atom_mass_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [31:0] force_x_i,
  input  logic signed [31:0] force_y_i,
  input  logic signed [31:0] force_z_i,
  input  logic        last_atom_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] new_pos_x_o,
  output logic signed [31:0] new_pos_y_o,
  output logic signed [31:0] new_pos_z_o,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o,
  output logic        in_group_o,
  output logic        saturated_o,
  output logic        sweep_end_o
);

  localparam int unsigned LaneStages = 4;

  logic [31:0] fsf_q, ts_q, grp_bits_q;
  logic        phase_q;
  logic        en;

  logic        v0_q;
  item_t       it0_q;
  logic [31:0] rem0_q, den0_q, num0_q;
  item_t       item_in;
  logic        grp_in, dsat_in;

  logic        dv_valid;
  item_t       dv_item;
  logic [31:0] quo, factor;

  logic        vl_q   [LaneStages];
  logic        gl_q   [LaneStages];
  logic        sl_q   [LaneStages];
  logic        ll_q   [LaneStages];
  logic [NumAxes-1:0][31:0] lpos, lvel;
  logic [NumAxes-1:0]       lsat;

  // whole pipeline moves unless a result is held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsf_q      <= 32'd32768;
      ts_q       <= 32'd65536;
      grp_bits_q <= 32'd1;
      phase_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegForceStep: fsf_q      <= cfg_data_i;
        RegTimeStep:  ts_q       <= cfg_data_i;
        RegGroup:     grp_bits_q <= cfg_data_i;
        RegPhase:     phase_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // group test and quotient overflow check (zero mass included)
  assign grp_in  = |(atom_mask_i & grp_bits_q);
  assign dsat_in = (atom_mass_i[31:16] == 16'd0) && (fsf_q[31:16] >= atom_mass_i[15:0]);

  always_comb begin
    item_in.pos  = {pos_z_i, pos_y_i, pos_x_i};
    item_in.vel  = {vel_z_i, vel_y_i, vel_x_i};
    item_in.frc  = {force_z_i, force_y_i, force_x_i};
    item_in.grp  = grp_in;
    item_in.sat  = grp_in & dsat_in;
    item_in.last = last_atom_i;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it0_q  <= item_in;
      rem0_q <= {16'd0, fsf_q[31:16]};
      den0_q <= atom_mass_i;
      num0_q <= {fsf_q[15:0], 16'd0};
    end
  end

  vva_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .item_i  (it0_q),
    .rem_i   (rem0_q),
    .den_i   (den0_q),
    .num_i   (num0_q),
    .valid_o (dv_valid),
    .item_o  (dv_item),
    .quo_o   (quo)
  );

  assign factor = dv_item.sat ? 32'hffff_ffff : quo;

  // per-axis lanes
  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    vva_lane u_lane (
      .clk_i       (clk_i),
      .en_i        (en),
      .factor_i    (factor),
      .time_step_i (ts_q),
      .phase_i     (phase_q),
      .grp_i       (dv_item.grp),
      .pos_i       (dv_item.pos[a]),
      .vel_i       (dv_item.vel[a]),
      .frc_i       (dv_item.frc[a]),
      .pos_o       (lpos[a]),
      .vel_o       (lvel[a]),
      .sat_o       (lsat[a])
    );
  end

  // flags alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LaneStages; k++) vl_q[k] <= 1'b0;
    end else if (en) begin
      vl_q[0] <= dv_valid;
      for (int k = 1; k < LaneStages; k++) vl_q[k] <= vl_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gl_q[0] <= dv_item.grp;
      sl_q[0] <= dv_item.sat;
      ll_q[0] <= dv_item.last;
      for (int k = 1; k < LaneStages; k++) begin
        gl_q[k] <= gl_q[k-1];
        sl_q[k] <= sl_q[k-1];
        ll_q[k] <= ll_q[k-1];
      end
    end
  end

  assign out_valid_o = vl_q[LaneStages-1];
  assign new_pos_x_o = lpos[0];
  assign new_pos_y_o = lpos[1];
  assign new_pos_z_o = lpos[2];
  assign new_vel_x_o = lvel[0];
  assign new_vel_y_o = lvel[1];
  assign new_vel_z_o = lvel[2];
  assign in_group_o  = gl_q[LaneStages-1];
  assign saturated_o = sl_q[LaneStages-1] | (|lsat);
  assign sweep_end_o = ll_q[LaneStages-1];

endmodule

[src/vva_checker.sv]
// port-level checks of the velocity verlet atom update
`include "assert_macros.svh"

module vva_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] new_vel_x_o,
  input logic        in_group_o,
  input logic        saturated_o
);

  // a held result keeps its valid and its x velocity
  `VVA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `VVA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(new_vel_x_o))
  // input stalls exactly while a result is held
  `VVA_ASSERT_IMPL(a_stall_link, clk_i, rst_ni, 1'b1, in_stall_o == (out_valid_o && out_stall_i))
  // a passed-through atom never reports a clamp
  `VVA_ASSERT_IMPL(a_pass_nosat, clk_i, rst_ni, out_valid_o && !in_group_o, !saturated_o)

endmodule

bind velocity_verlet_atom_update vva_checker u_vva_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .new_vel_x_o (new_vel_x_o),
  .in_group_o  (in_group_o),
  .saturated_o (saturated_o)
);
